FILE: hw/rtl/fbpa_pkg.sv
// Shared constants, codes and the chain token type of the fixed block pool allocator.
// No dependencies; used by fbpa_cell and fixed_block_pool_allocator.
package fbpa_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int CELL_DEPTH = 32;
  localparam int CELL_AW    = $clog2(CELL_DEPTH);
  localparam int N_CELLS    = MAX_BLOCKS / CELL_DEPTH;
  localparam int CELL_ID_W  = IDX_W - CELL_AW;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  // One link store access travelling down the row of cells.
  // data holds {link valid, link} for a write and picks up the entry on a read.
  typedef struct packed {
    logic             active;
    logic             wr;
    logic [IDX_W-1:0] addr;
    logic [IDX_W:0]   data;
  } tok_t;

endpackage

FILE: hw/rtl/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator: free-list head, watermark and result logic.
// Instantiates the row of fbpa_cell link store cells; depends on fbpa_pkg.
//
// Each request gives one result on status/granted_index, marked by done, in the
// cycle after start is taken; the receiver cannot stall it. Frees, grants from
// the never-used range and exhausted or out-of-range requests do not raise
// busy. A grant that pops the freed list keeps busy high until the successor
// link has come back through the row of N_CELLS link cells (one cell per
// cycle) and has been loaded into the head.
// Writing block_count empties the freed list and restarts the watermark at zero;
// there is no clearing pass after reset.
module fixed_block_pool_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         req_type,
  input  logic [fbpa_pkg::IDX_W-1:0]   block_index,
  input  logic                         cfg_we,
  input  logic [fbpa_pkg::CNT_W-1:0]   cfg_data,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [fbpa_pkg::IDX_W-1:0]   granted_index
);

  fbpa_pkg::tok_t chain [fbpa_pkg::N_CELLS+1];

  logic [fbpa_pkg::CNT_W-1:0] block_count;
  logic [fbpa_pkg::CNT_W-1:0] eff_cnt;
  logic [fbpa_pkg::CNT_W-1:0] watermark;
  logic [fbpa_pkg::IDX_W-1:0] list_head;
  logic                       list_nonempty;
  logic                       waiting;
  logic                       accept;
  logic                       pop;
  logic                       fresh;
  logic                       free_ok;
  logic                       link_back;

  assign busy    = waiting;
  assign accept  = start && !busy;
  assign eff_cnt = (block_count > fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS)) ?
                   fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS) : block_count;

  assign pop     = (req_type == fbpa_pkg::REQ_ALLOC) && list_nonempty;
  assign fresh   = (req_type == fbpa_pkg::REQ_ALLOC) && !list_nonempty &&
                   (watermark < eff_cnt);
  assign free_ok = (req_type == fbpa_pkg::REQ_FREE) && ({1'b0, block_index} < eff_cnt);

  // launch a link write on an in-range free, a link read on a pop
  always_comb begin
    chain[0].active = accept && (pop || free_ok);
    chain[0].wr     = (req_type == fbpa_pkg::REQ_FREE);
    chain[0].addr   = pop ? list_head : block_index;
    chain[0].data   = {list_nonempty, list_head};
  end

  for (genvar g = 0; g < fbpa_pkg::N_CELLS; g++) begin : g_cell
    fbpa_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_id (fbpa_pkg::CELL_ID_W'(g)),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  assign link_back = chain[fbpa_pkg::N_CELLS].active && !chain[fbpa_pkg::N_CELLS].wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count   <= fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS);
      list_head     <= '0;
      list_nonempty <= 1'b0;
      watermark     <= '0;
      waiting       <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= accept;
      if (cfg_we) begin
        block_count   <= cfg_data;
        list_head     <= '0;
        list_nonempty <= 1'b0;
        watermark     <= '0;
      end else if (accept) begin
        if (free_ok) begin
          list_head     <= block_index;
          list_nonempty <= 1'b1;
        end
        if (fresh) begin
          watermark <= watermark + 1'b1;
        end
      end else if (link_back) begin
        list_head     <= chain[fbpa_pkg::N_CELLS].data[fbpa_pkg::IDX_W-1:0];
        list_nonempty <= chain[fbpa_pkg::N_CELLS].data[fbpa_pkg::IDX_W];
      end
      // hold off new requests until the popped head's successor returns
      if (accept && pop) begin
        waiting <= 1'b1;
      end else if (link_back) begin
        waiting <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (pop) begin
        status        <= fbpa_pkg::ST_OK;
        granted_index <= list_head;
      end else if (fresh) begin
        status        <= fbpa_pkg::ST_OK;
        granted_index <= watermark[fbpa_pkg::IDX_W-1:0];
      end else if (req_type == fbpa_pkg::REQ_ALLOC) begin
        status        <= fbpa_pkg::ST_EXHAUSTED;
        granted_index <= '0;
      end else if (free_ok) begin
        status        <= fbpa_pkg::ST_OK;
        granted_index <= '0;
      end else begin
        status        <= fbpa_pkg::ST_RANGE;
        granted_index <= '0;
      end
    end
  end

endmodule

FILE: hw/rtl/fbpa_cell.sv
// One cell of the link store chain: owns CELL_DEPTH free-list links and passes
// the access token to its neighbor every cycle. Depends on fbpa_pkg.
module fbpa_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [fbpa_pkg::CELL_ID_W-1:0] cell_id,
  input  fbpa_pkg::tok_t                 tok_in,
  output fbpa_pkg::tok_t                 tok_out
);

  logic [fbpa_pkg::IDX_W:0]     entry [fbpa_pkg::CELL_DEPTH];
  logic                         hit;
  logic [fbpa_pkg::CELL_AW-1:0] slot;

  assign hit  = tok_in.active &&
                (tok_in.addr[fbpa_pkg::IDX_W-1 -: fbpa_pkg::CELL_ID_W] == cell_id);
  assign slot = tok_in.addr[fbpa_pkg::CELL_AW-1:0];

  always_ff @(posedge clk) begin
    if (hit && tok_in.wr) begin
      entry[slot] <= tok_in.data;
    end
  end

  always_ff @(posedge clk) begin
    tok_out.wr   <= tok_in.wr;
    tok_out.addr <= tok_in.addr;
    // pick up the link on a read that lands here, else pass the data along
    tok_out.data <= (hit && !tok_in.wr) ? entry[slot] : tok_in.data;
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_in.active;
    end
  end

endmodule

FILE: sim/fbpa_checker.sv
// Checker for the fixed block pool allocator: tracks the free list and watermark,
// predicts every result and compares it against the done strobe. Depends on fbpa_pkg.
module fbpa_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       req_type,
  input  logic [fbpa_pkg::IDX_W-1:0] block_index,
  input  logic                       cfg_we,
  input  logic [fbpa_pkg::CNT_W-1:0] cfg_data,
  input  logic                       done,
  input  logic [1:0]                 status,
  input  logic [fbpa_pkg::IDX_W-1:0] granted_index,
  output int                         fail_count,
  output int                         pending
);

  typedef struct packed {
    logic [1:0]                 status;
    logic [fbpa_pkg::IDX_W-1:0] index;
  } grant_t;

  grant_t                     expected_grants[$];
  logic [fbpa_pkg::IDX_W-1:0] link_mem[fbpa_pkg::MAX_BLOCKS];
  logic                       link_ok[fbpa_pkg::MAX_BLOCKS];
  logic [fbpa_pkg::IDX_W-1:0] head;
  logic                       has_freed;
  logic [fbpa_pkg::CNT_W-1:0] mark;
  logic [fbpa_pkg::CNT_W-1:0] pool_size;

  // Pop the freed list first, then the never-used range; push frees onto the head.
  function automatic grant_t serve_request(input logic rt,
                                           input logic [fbpa_pkg::IDX_W-1:0] idx);
    grant_t      r;
    int unsigned usable;
    r.status = fbpa_pkg::ST_OK;
    r.index  = '0;
    usable   = (pool_size > fbpa_pkg::MAX_BLOCKS) ? fbpa_pkg::MAX_BLOCKS : pool_size;
    if (rt == fbpa_pkg::REQ_ALLOC) begin
      if (has_freed) begin
        r.index   = head;
        has_freed = link_ok[head];
        head      = link_mem[head];
      end else if (mark < usable) begin
        r.index = mark[fbpa_pkg::IDX_W-1:0];
        mark    = mark + 1'b1;
      end else begin
        r.status = fbpa_pkg::ST_EXHAUSTED;
      end
    end else if (idx < usable) begin
      link_mem[idx] = head;
      link_ok[idx]  = has_freed;
      head          = idx;
      has_freed     = 1'b1;
    end else begin
      r.status = fbpa_pkg::ST_RANGE;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      expected_grants.delete();
      pool_size  = fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS);
      head       = '0;
      has_freed  = 1'b0;
      mark       = '0;
      fail_count = 0;
      for (int i = 0; i < fbpa_pkg::MAX_BLOCKS; i++) begin
        link_mem[i] = '0;
        link_ok[i]  = 1'b0;
      end
    end else begin
      // Retire the finished transfer before queueing a new one.
      if (done) begin
        if (expected_grants.size() == 0) begin
          $error("unexpected result: status %0d, granted_index %0d", status, granted_index);
          fail_count++;
        end else begin
          want = expected_grants.pop_front();
          if (status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, status);
            fail_count++;
          end
          if (granted_index !== want.index) begin
            $error("granted_index mismatch: expected %0d, got %0d", want.index, granted_index);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        pool_size = cfg_data;
        head      = '0;
        has_freed = 1'b0;
        mark      = '0;
      end
      if (start && !busy)
        expected_grants.push_back(serve_request(req_type, block_index));
    end
    pending = expected_grants.size();
  end

endmodule

FILE: sim/tb_top.sv
// Testbench top for fixed_block_pool_allocator: drives allocate and free requests
// and block_count writes, and gives the verdict from fbpa_checker. Depends on fbpa_pkg.
module tb_top;

  localparam int LIMIT       = 400000;
  localparam int PHASE_ITEMS = 90;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic                       req_type;
  logic [fbpa_pkg::IDX_W-1:0] block_index;
  logic                       cfg_we;
  logic [fbpa_pkg::CNT_W-1:0] cfg_data;
  logic                       done;
  logic [1:0]                 status;
  logic [fbpa_pkg::IDX_W-1:0] granted_index;
  int                         fail_count;
  int                         pending;
  int                         cycles = 0;
  int                         pool_size = fbpa_pkg::MAX_BLOCKS;
  int                         gap_pct = 18;

  fixed_block_pool_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .block_index  (block_index),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .done         (done),
    .status       (status),
    .granted_index(granted_index)
  );

  fbpa_checker chk (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .block_index  (block_index),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .done         (done),
    .status       (status),
    .granted_index(granted_index),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Hold the request until a transfer happens, go to the next falling edge, then maybe idle.
  task automatic request(input logic rt, input logic [fbpa_pkg::IDX_W-1:0] idx);
    start       <= 1'b1;
    req_type    <= rt;
    block_index <= idx;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if ($urandom_range(0, 99) < gap_pct) begin
      start       <= 1'b0;
      req_type    <= 1'($urandom);
      block_index <= fbpa_pkg::IDX_W'($urandom);
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  // Wait for every outstanding result and for a pop walk to settle.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_count(input logic [fbpa_pkg::CNT_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_data  <= v;
    pool_size = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int usable;
    int alloc_pct;
    logic [fbpa_pkg::CNT_W-1:0] settings[6];
    settings = '{9'd256, 9'd5, 9'd32, 9'd2, 9'd511, 9'd100};

    rst         = 1'b1;
    start       = 1'b0;
    req_type    = fbpa_pkg::REQ_ALLOC;
    block_index = '0;
    cfg_we      = 1'b0;
    cfg_data    = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset pool: watermark grants, LIFO reuse, double free of the top index.
    request(fbpa_pkg::REQ_ALLOC, 8'd0);
    request(fbpa_pkg::REQ_ALLOC, 8'd0);
    request(fbpa_pkg::REQ_ALLOC, 8'd0);
    request(fbpa_pkg::REQ_FREE,  8'd1);
    request(fbpa_pkg::REQ_FREE,  8'd0);
    request(fbpa_pkg::REQ_ALLOC, 8'hff);
    request(fbpa_pkg::REQ_ALLOC, 8'd0);
    request(fbpa_pkg::REQ_FREE,  8'd255);
    request(fbpa_pkg::REQ_FREE,  8'd255);
    request(fbpa_pkg::REQ_ALLOC, 8'd0);
    request(fbpa_pkg::REQ_ALLOC, 8'd0);
    request(fbpa_pkg::REQ_ALLOC, 8'd0);
    request(fbpa_pkg::REQ_FREE,  8'd128);
    request(fbpa_pkg::REQ_ALLOC, 8'd0);

    // Single-block pool: exhaustion and out-of-range frees.
    write_count(9'd1);
    request(fbpa_pkg::REQ_ALLOC, 8'd0);
    request(fbpa_pkg::REQ_ALLOC, 8'd0);
    request(fbpa_pkg::REQ_FREE,  8'd1);
    request(fbpa_pkg::REQ_FREE,  8'd0);
    request(fbpa_pkg::REQ_ALLOC, 8'd0);
    request(fbpa_pkg::REQ_FREE,  8'd255);

    // Empty pool, then a count that saturates.
    write_count(9'd0);
    request(fbpa_pkg::REQ_ALLOC, 8'd0);
    request(fbpa_pkg::REQ_FREE,  8'd0);
    write_count(9'd300);
    request(fbpa_pkg::REQ_ALLOC, 8'd0);
    request(fbpa_pkg::REQ_FREE,  8'd255);

    for (int p = 0; p < 6; p++) begin
      write_count(settings[p]);
      gap_pct   = (p < 2) ? 18 : (p < 4) ? 86 : 0;
      usable    = (pool_size > fbpa_pkg::MAX_BLOCKS) ? fbpa_pkg::MAX_BLOCKS : pool_size;
      alloc_pct = (usable > 64) ? 70 : 55;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 3 && i == PHASE_ITEMS / 2)
          drain();
        if ($urandom_range(0, 99) < alloc_pct)
          request(fbpa_pkg::REQ_ALLOC, fbpa_pkg::IDX_W'($urandom));
        else if ($urandom_range(0, 99) < 70)
          request(fbpa_pkg::REQ_FREE, fbpa_pkg::IDX_W'($urandom_range(0, usable - 1)));
        else
          request(fbpa_pkg::REQ_FREE, fbpa_pkg::IDX_W'($urandom));
      end
    end

    drain();
    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
